>>> rtl/yhe_pkg.sv
// Yaw heading extract package: widths, item and cell-chain types, identity constant.
// Used by yhe_prep, yhe_cell and yaw_heading_extract_top; no dependencies.
package yhe_pkg;

	localparam int FRAC_BITS = 14;
	localparam int IW        = 16;
	localparam int MW        = 16;
	localparam int NUM_CELLS = MW;
	localparam int SQW       = 2 * IW;
	localparam int DW        = (2 * FRAC_BITS + 35 > 68) ? 2 * FRAC_BITS + 35 : 68;
	localparam int R_SH      = 2 * FRAC_BITS + 2;
	localparam int Q_SH      = MW + 1;
	localparam int S_SH      = 2 * MW;

	localparam logic [IW-1:0] IDENT_COS = (FRAC_BITS > IW - 2) ? {1'b0, {(IW-1){1'b1}}} :
		IW'(1 << FRAC_BITS);

	// first member sits in the highest bits, so x_col_x lands in bits [15:0]
	typedef struct packed {
		logic signed [IW-1:0] z_col_z;
		logic signed [IW-1:0] y_col_y;
		logic signed [IW-1:0] y_col_x;
		logic signed [IW-1:0] x_col_y;
		logic signed [IW-1:0] x_col_x;
	} in_t;

	typedef struct packed {
		logic signed [DW-1:0] d;
		logic signed [DW-1:0] q;
		logic [MW-1:0]        m;
		logic                 neg;
	} lane_t;

	typedef struct packed {
		lane_t                lane_cos;
		lane_t                lane_sin;
		logic signed [DW-1:0] sq;
		logic                 used_x;
		logic                 degen;
	} cell_t;

endpackage

>>> rtl/yhe_prep.sv
// Front end: column select, flip, magnitudes and squares, then search seed values.
// Two pipeline stages with per-stage valid; uses yhe_pkg.
module yhe_prep (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  yhe_pkg::in_t      in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output yhe_pkg::cell_t    out_data
);

	logic signed [yhe_pkg::IW:0] vx, vy;
	logic [yhe_pkg::IW:0]        abs_x, abs_y;
	logic [yhe_pkg::IW-1:0]      ax, ay;
	logic                        use_x;

	logic                        v_s1, v_s2;
	logic                        en_s1, en_s2;
	logic [yhe_pkg::SQW-1:0]     ax2_s1, ay2_s1;
	logic                        neg_c_s1, neg_s_s1, used_x_s1, degen_s1;

	logic [yhe_pkg::SQW:0]       s_sum;
	logic signed [yhe_pkg::DW-1:0] s_ext, ax2_ext, ay2_ext;
	yhe_pkg::cell_t              seed;
	yhe_pkg::cell_t              data_s2;

	always_comb begin
		use_x = (in_data.y_col_x == '0) && (in_data.y_col_y == '0);
		if (use_x) begin
			vx = (yhe_pkg::IW+1)'(in_data.x_col_x);
			vy = (yhe_pkg::IW+1)'(in_data.x_col_y);
		end else if (in_data.z_col_z > 0) begin
			vx = (yhe_pkg::IW+1)'(in_data.y_col_y);
			vy = -(yhe_pkg::IW+1)'(in_data.y_col_x);
		end else begin
			vx = -(yhe_pkg::IW+1)'(in_data.y_col_y);
			vy = (yhe_pkg::IW+1)'(in_data.y_col_x);
		end
		abs_x = vx[yhe_pkg::IW] ? (yhe_pkg::IW+1)'(-vx) : (yhe_pkg::IW+1)'(vx);
		abs_y = vy[yhe_pkg::IW] ? (yhe_pkg::IW+1)'(-vy) : (yhe_pkg::IW+1)'(vy);
		ax    = abs_x[yhe_pkg::IW-1:0];
		ay    = abs_y[yhe_pkg::IW-1:0];
	end

	assign en_s2    = !v_s2 || out_ready;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			ax2_s1    <= ax * ax;
			ay2_s1    <= ay * ay;
			neg_c_s1  <= vx[yhe_pkg::IW];
			neg_s_s1  <= vy[yhe_pkg::IW];
			used_x_s1 <= use_x;
			degen_s1  <= (vx == '0) && (vy == '0);
		end
	end

	// seed at the top bit: D = 4*a^2*2^(2F) - s, Q = -s*2^17, S = s*2^32
	always_comb begin
		s_sum   = {1'b0, ax2_s1} + {1'b0, ay2_s1};
		s_ext   = yhe_pkg::DW'(s_sum);
		ax2_ext = yhe_pkg::DW'(ax2_s1);
		ay2_ext = yhe_pkg::DW'(ay2_s1);
		seed.lane_cos.d   = (ax2_ext <<< yhe_pkg::R_SH) - s_ext;
		seed.lane_cos.q   = -(s_ext <<< yhe_pkg::Q_SH);
		seed.lane_cos.m   = '0;
		seed.lane_cos.neg = neg_c_s1;
		seed.lane_sin.d   = (ay2_ext <<< yhe_pkg::R_SH) - s_ext;
		seed.lane_sin.q   = -(s_ext <<< yhe_pkg::Q_SH);
		seed.lane_sin.m   = '0;
		seed.lane_sin.neg = neg_s_s1;
		seed.sq           = s_ext <<< yhe_pkg::S_SH;
		seed.used_x       = used_x_s1;
		seed.degen        = degen_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			data_s2 <= seed;
		end
	end

	assign out_valid = v_s2;
	assign out_data  = data_s2;

endmodule

>>> rtl/yhe_cell.sv
// One search cell: decides one result bit of both heading components.
// Identical cells shift the scaled terms down for the next bit; uses yhe_pkg.
module yhe_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  yhe_pkg::cell_t    in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output yhe_pkg::cell_t    out_data
);

	function automatic yhe_pkg::lane_t lane_step(input yhe_pkg::lane_t l,
			input logic signed [yhe_pkg::DW-1:0] sq);
		yhe_pkg::lane_t                r;
		logic signed [yhe_pkg::DW-1:0] d_in, q_in, dn, qs;
		logic                          acc;
		d_in  = l.d;
		q_in  = l.q;
		dn    = d_in - q_in - sq;
		acc   = !dn[yhe_pkg::DW-1];
		qs    = acc ? q_in + (sq <<< 1) : q_in;
		r.d   = acc ? dn : d_in;
		r.q   = qs >>> 1;
		r.m   = {l.m[yhe_pkg::MW-2:0], acc};
		r.neg = l.neg;
		return r;
	endfunction

	logic           v_q;
	logic           en;
	yhe_pkg::cell_t nxt;
	yhe_pkg::cell_t data_q;

	always_comb begin
		nxt          = in_data;
		nxt.lane_cos = lane_step(in_data.lane_cos, in_data.sq);
		nxt.lane_sin = lane_step(in_data.lane_sin, in_data.sq);
		nxt.sq       = in_data.sq >>> 2;
	end

	assign en       = !v_q || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= nxt;
		end
	end

	assign out_valid = v_q;
	assign out_data  = data_q;

endmodule

>>> rtl/yaw_heading_extract_top.sv
// Yaw heading extract: two front-end stages, sixteen search cells and an output
// register; one cell per result bit runs the rounding search.
// Throughput one item per cycle unless the output stalls.
// Stages advance independently, so bubbles close up behind a stalled output.
// arst_n clears all valid bits; payload registers are not reset.
module yaw_heading_extract_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,  // x_col_x, x_col_y, y_col_x, y_col_y, z_col_z
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // cos_yaw, sin_yaw
	output logic [1:0]  m_tuser   // used_x_axis, degenerate
);

	function automatic logic [yhe_pkg::IW-1:0] comp_out(input logic [yhe_pkg::MW-1:0] m,
			input logic neg);
		logic [yhe_pkg::IW:0] mag;
		logic [yhe_pkg::IW:0] nv;
		if (neg) begin
			mag = (m > 16'h8000) ? 17'h08000 : {1'b0, m};
			nv  = 17'd0 - mag;
		end else begin
			mag = (m > 16'h7FFF) ? 17'h07FFF : {1'b0, m};
			nv  = mag;
		end
		return nv[yhe_pkg::IW-1:0];
	endfunction

	yhe_pkg::cell_t chain_data [0:yhe_pkg::NUM_CELLS];
	logic           chain_valid[0:yhe_pkg::NUM_CELLS];
	logic           chain_ready[0:yhe_pkg::NUM_CELLS];

	logic        out_v_q;
	logic [31:0] tdata_q;
	logic [1:0]  tuser_q;
	logic        out_en;
	yhe_pkg::cell_t last;

	yhe_prep u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_data   (yhe_pkg::in_t'(s_tdata)),
		.out_valid (chain_valid[0]),
		.out_ready (chain_ready[0]),
		.out_data  (chain_data[0])
	);

	for (genvar i = 0; i < yhe_pkg::NUM_CELLS; i++) begin : g_cell
		yhe_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (chain_valid[i]),
			.in_ready  (chain_ready[i]),
			.in_data   (chain_data[i]),
			.out_valid (chain_valid[i+1]),
			.out_ready (chain_ready[i+1]),
			.out_data  (chain_data[i+1])
		);
	end

	assign last   = chain_data[yhe_pkg::NUM_CELLS];
	assign out_en = !out_v_q || m_tready;
	assign chain_ready[yhe_pkg::NUM_CELLS] = out_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_en) begin
			out_v_q <= chain_valid[yhe_pkg::NUM_CELLS];
		end
	end

	always_ff @(posedge clk) begin
		if (out_en) begin
			if (last.degen) begin
				tdata_q <= {{yhe_pkg::IW{1'b0}}, yhe_pkg::IDENT_COS};
			end else begin
				tdata_q <= {comp_out(last.lane_sin.m, last.lane_sin.neg),
					comp_out(last.lane_cos.m, last.lane_cos.neg)};
			end
			tuser_q <= {last.degen, last.used_x};
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = tdata_q;
	assign m_tuser  = tuser_q;

`ifndef SYNTHESIS
	a_degen_is_fallback: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tuser[0])
		else $error("degenerate result without X column fallback");

	a_degen_identity: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> (m_tdata[15:0] == yhe_pkg::IDENT_COS) &&
			(m_tdata[31:16] == 16'd0))
		else $error("degenerate result is not the identity heading");

	a_empty_out_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled while output register is empty");
`endif

endmodule
